FILE: rtl/core/adsr_pkg.sv
package adsr_pkg;

   localparam int LEVEL_BITS = 16;
   localparam int TIME_BITS  = 24;
   localparam int STEP_FRAC  = 32 - LEVEL_BITS;
   localparam int DIV_BITS   = 48;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_TRIGGER = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ATTACK  = 3'd1;
   localparam logic [2:0] PH_DECAY   = 3'd2;
   localparam logic [2:0] PH_SUSTAIN = 3'd3;
   localparam logic [2:0] PH_RELEASE = 3'd4;

   localparam logic [1:0] SHAPE_EXP   = 2'd0;
   localparam logic [1:0] SHAPE_PARAB = 2'd1;
   localparam logic [1:0] SHAPE_LIN   = 2'd2;
   localparam logic [1:0] SHAPE_INST  = 2'd3;

   localparam logic [2:0] REG_MAX     = 3'd0;
   localparam logic [2:0] REG_MIN     = 3'd1;
   localparam logic [2:0] REG_ATTACK  = 3'd2;
   localparam logic [2:0] REG_DECAY   = 3'd3;
   localparam logic [2:0] REG_SUSTAIN = 3'd4;
   localparam logic [2:0] REG_SHAPE   = 3'd5;
   localparam logic [2:0] REG_RATE    = 3'd6;

endpackage

FILE: rtl/core/adsr_div.sv
// Restoring divider, one quotient bit per cycle
module adsr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [adsr_pkg::DIV_BITS-1:0]  dividend,
   input  logic [adsr_pkg::TIME_BITS-1:0] divisor,
   output logic [adsr_pkg::DIV_BITS-1:0]  quotient,
   output logic                           done
);
   import adsr_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [TIME_BITS:0]   rem_ff, rem_in;
   logic [TIME_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 run_ff, run_in, done_ff, done_in;
   logic [TIME_BITS+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_BITS-1]} - {2'b00, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_BITS'(DIV_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift one dividend bit into the remainder and try a subtract
         if (!trial[TIME_BITS+1]) begin
            rem_in = trial[TIME_BITS:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[TIME_BITS-1:0], quo_ff[DIV_BITS-1]};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

FILE: rtl/core/adsr_mul.sv
// Shift-add multiplier, one multiplier bit per cycle
module adsr_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] mcand,
   input  logic [31:0] mplier,
   output logic [63:0] product,
   output logic        done
);
   import adsr_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] mc_ff, mc_in;
   logic [31:0] mp_ff, mp_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mc_in  = {24'd0, mcand};
         mp_in  = mplier;
         cnt_in = 6'd32;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = {mc_ff[62:0], 1'b0};
         mp_in  = {1'b0, mp_ff[31:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;
endmodule

FILE: rtl/core/adsr_envelope_generator_unit.sv
// ADSR envelope generator.
// req_ channel: one command per transfer. tdata = {level_in[15:0], cmd[1:0]}
// (cmd lowest, zero filled to 24 bits). cmd 0 tick, 1 trigger, 2 release.
// rsp_ channel: one result per command. tdata = {phase, active, level_out}
// (level_out lowest, zero filled to 24 bits).
// csr_ channel: register index and write data; write only while idle.
// Path from an accepted command to rsp_tvalid: release, unknown commands, idle
// ticks and triggers that do not raise the level go straight to the output
// state; a sustain, instant or first exponential release tick passes the tick
// and finish states; other ticks add one serial multiply (ramp offset, linear
// drop or retention), a parabolic release tick two multiplies, and a trigger
// that raises the level two serial divisions for the slopes. One command is
// in work at a time; the next is taken from the cycle the result is presented.
// A finished result waits in the output register while req_tready rises for
// the next command, so a stalled receiver holds only that one result.
// Reset is synchronous: control, configuration and envelope registers return to
// their reset values (data registers do not); the envelope is idle at level 0.
module adsr_envelope_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd[1:0], level_in[17:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // level_out[15:0], active[16], phase[19:17]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import adsr_pkg::*;

   localparam logic [31:0] STEP_LIM = 32'h7FFF_FFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_A, S_DIV_D, S_TICK, S_MUL1, S_MUL2, S_FINISH, S_OUT
   } state_type;

   // configuration
   logic [15:0] max_ff, min_ff, rate_ff;
   logic [23:0] atk_ff, dec_ff;
   logic [24:0] sus_ff;
   logic [1:0]  shape_ff;

   // envelope state
   logic [15:0] level_ff, sus_lvl_ff, expf_ff;
   logic [23:0] elapsed_ff;
   logic [31:0] astep_ff, dstep_ff;
   logic        active_ff, held_ff;

   state_type   state_ff;
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        div_go_ff, div_go_in, mul_go_ff, mul_go_in;
   logic        div_done, mul_done;
   logic        out_load;

   logic [DIV_BITS-1:0]  div_dvd, div_q;
   logic [TIME_BITS-1:0] div_dvs;
   logic [39:0]          mul_a;
   logic [31:0]          mul_b;
   logic [63:0]          mul_p;

   // derived timing points
   logic [24:0] sus_start;
   logic [25:0] rel_point;
   logic [16:0] diff_a, diff_d;
   logic [23:0] t_left;
   logic [23:0] t_dec;
   logic [31:0] sat_q;
   logic [16:0] exp_f;
   logic [15:0] lvl_above;
   logic [2:0]  ph_next;
   logic        tick_mul;

   // level arithmetic
   logic [41:0]        off;
   logic [17:0]        sum_up, sum_exp0, sum_exp;
   logic [15:0]        lvl_up, lvl_dn;
   logic [63:0]        drop;
   logic signed [42:0] v;

   adsr_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff), .dividend(div_dvd),
      .divisor(div_dvs), .quotient(div_q), .done(div_done)
   );
   adsr_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_go_ff), .mcand(mul_a),
      .mplier(mul_b), .product(mul_p), .done(mul_done)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   assign sus_start = {1'b0, atk_ff} + {1'b0, dec_ff};
   assign rel_point = {1'b0, sus_start} + {1'b0, sus_ff};
   assign diff_a    = {1'b0, max_ff} - {1'b0, level_ff};
   assign diff_d    = {1'b0, sus_lvl_ff} - {1'b0, max_ff};
   assign t_left    = atk_ff - elapsed_ff - 24'd1;
   assign t_dec     = elapsed_ff - atk_ff;
   assign sat_q     = (div_q > DIV_BITS'(STEP_LIM)) ? STEP_LIM : div_q[31:0];
   assign exp_f     = 17'h10000 - {1'b0, rate_ff};
   assign lvl_above = (level_ff > min_ff) ? level_ff - min_ff : 16'd0;

   always_comb begin
      if (!active_ff)                              ph_next = PH_IDLE;
      else if (!held_ff)                           ph_next = PH_RELEASE;
      else if (elapsed_ff < atk_ff)                ph_next = PH_ATTACK;
      else if ({1'b0, elapsed_ff} < sus_start)     ph_next = PH_DECAY;
      else                                         ph_next = PH_SUSTAIN;
   end

   // start pulses for the serial units
   always_comb begin
      tick_mul = !(held_ff && {1'b0, elapsed_ff} >= sus_start) &&
                 !(!held_ff && shape_ff == SHAPE_INST) &&
                 !(!held_ff && shape_ff == SHAPE_EXP && elapsed_ff == 24'd0);
      div_go_in = ((state_ff == S_IDLE) && req_tvalid && req_tready &&
                   (req_tdata[1:0] == CMD_TRIGGER) && (req_tdata[17:2] > level_ff)) ||
                  ((state_ff == S_DIV_A) && div_done);
      mul_go_in = ((state_ff == S_TICK) && tick_mul) ||
                  ((state_ff == S_MUL1) && mul_done && !held_ff &&
                   (shape_ff == SHAPE_PARAB));
   end

   // unit operands, chosen by the state in which the unit starts
   always_comb begin
      div_dvd = '0;
      div_dvs = atk_ff;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_DIV_A: begin
            div_dvd = DIV_BITS'({diff_a[16] ? -diff_a : diff_a, 16'd0});
            div_dvs = atk_ff;
         end
         S_DIV_D: begin
            div_dvd = DIV_BITS'({diff_d[16] ? -diff_d : diff_d, 16'd0});
            div_dvs = dec_ff;
         end
         S_MUL1: begin
            if (held_ff && elapsed_ff < atk_ff) begin
               mul_a = {8'd0, astep_ff[31] ? -astep_ff : astep_ff};
               mul_b = {8'd0, t_left};
            end else if (held_ff) begin
               mul_a = {8'd0, dstep_ff[31] ? -dstep_ff : dstep_ff};
               mul_b = {8'd0, t_dec};
            end else if (shape_ff == SHAPE_EXP) begin
               mul_a = {24'd0, lvl_above};
               mul_b = {16'd0, expf_ff};
            end else begin
               mul_a = {24'd0, rate_ff};
               mul_b = {8'd0, elapsed_ff};
            end
         end
         S_MUL2: begin
            // rate * t times t again for the parabola
            mul_a = prod_ff[39:0];
            mul_b = {8'd0, elapsed_ff};
         end
         default: ;
      endcase
   end

   // ramp, retention and release drop levels
   always_comb begin
      off      = prod_ff[57:16];
      sum_up   = {2'b0, max_ff} + ((off > 42'hFFFF) ? 18'h1FFFF : {2'b0, off[15:0]});
      lvl_up   = (sum_up > 18'hFFFF) ? 16'hFFFF : sum_up[15:0];
      lvl_dn   = (off >= {26'd0, max_ff}) ? 16'd0 : max_ff - off[15:0];
      sum_exp0 = {2'b0, min_ff} + {2'b0, sus_lvl_ff};
      sum_exp  = {2'b0, min_ff} + {2'b0, prod_ff[31:16]};
      if (shape_ff == SHAPE_PARAB) begin
         if (elapsed_ff >= 24'h100000)
            drop = (rate_ff != 0) ? 64'h100_0000_0000 : 64'd0;
         else drop = {8'd0, mul_p[63:8]};
      end else drop = {8'd0, prod_ff[63:8]};
      if (drop > 64'h100_0000_0000) drop = 64'h100_0000_0000;
      v = $signed({27'd0, sus_lvl_ff}) - $signed({2'b0, drop[40:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= 16'hFFFF;
         min_ff       <= '0;
         atk_ff       <= '0;
         dec_ff       <= '0;
         sus_ff       <= '1;
         shape_ff     <= SHAPE_LIN;
         rate_ff      <= 16'd256;
         level_ff     <= '0;
         sus_lvl_ff   <= '0;
         expf_ff      <= 16'hFFFF;
         elapsed_ff   <= '0;
         astep_ff     <= '0;
         dstep_ff     <= '0;
         active_ff    <= 1'b0;
         held_ff      <= 1'b0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
      end else begin
         div_go_ff <= div_go_in;
         mul_go_ff <= mul_go_in;
         // result register: load a finished result, clear after its transfer
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX:     max_ff   <= csr_data[15:0];
               REG_MIN:     min_ff   <= csr_data[15:0];
               REG_ATTACK:  atk_ff   <= csr_data[23:0];
               REG_DECAY:   dec_ff   <= csr_data[23:0];
               REG_SUSTAIN: sus_ff   <= csr_data[24:0];
               REG_SHAPE:   shape_ff <= csr_data[1:0];
               REG_RATE:    rate_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  case (req_tdata[1:0])
                     CMD_TICK:
                        state_ff <= active_ff ? S_TICK : S_OUT;
                     CMD_TRIGGER: begin
                        active_ff <= 1'b1;
                        held_ff   <= 1'b1;
                        if (req_tdata[17:2] > level_ff) begin
                           sus_lvl_ff <= req_tdata[17:2];
                           elapsed_ff <= '0;
                           state_ff   <= S_DIV_A;
                        end else state_ff <= S_OUT;
                     end
                     CMD_RELEASE: begin
                        elapsed_ff <= '0;
                        held_ff    <= 1'b0;
                        expf_ff    <= exp_f[16] ? 16'hFFFF : exp_f[15:0];
                        state_ff   <= S_OUT;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_DIV_A: begin
               if (div_done) begin
                  astep_ff <= (atk_ff == '0) ? 32'd0 : (diff_a[16] ? -sat_q : sat_q);
                  state_ff <= S_DIV_D;
               end
            end
            S_DIV_D: begin
               if (div_done) begin
                  dstep_ff <= (dec_ff == '0) ? 32'd0 : (diff_d[16] ? -sat_q : sat_q);
                  state_ff <= S_OUT;
               end
            end
            S_TICK: begin
               // sustain, instant and the first exponential release tick need no multiply
               if (held_ff && {1'b0, elapsed_ff} >= sus_start) begin
                  level_ff <= sus_lvl_ff;
                  if (!sus_ff[24] && {2'b0, elapsed_ff} >= rel_point) begin
                     elapsed_ff <= '0;
                     held_ff    <= 1'b0;
                     expf_ff    <= exp_f[16] ? 16'hFFFF : exp_f[15:0];
                  end
                  state_ff <= S_FINISH;
               end else if (!held_ff && shape_ff == SHAPE_INST) begin
                  neg_ff   <= 1'b1;
                  state_ff <= S_FINISH;
               end else if (!held_ff && shape_ff == SHAPE_EXP && elapsed_ff == 0) begin
                  level_ff <= sum_exp0[16] ? 16'hFFFF : sum_exp0[15:0];
                  neg_ff   <= (sus_lvl_ff == 0);
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_MUL1;
                  neg_ff   <= 1'b0;
               end
            end
            S_MUL1: begin
               if (mul_done) begin
                  prod_ff  <= mul_p;
                  state_ff <= S_MUL2;
               end
            end
            S_MUL2: begin
               if (!held_ff && shape_ff == SHAPE_PARAB && !mul_done) begin
                  // wait for the second multiply
               end else begin
                  if (held_ff) begin
                     if (elapsed_ff < atk_ff)
                        level_ff <= astep_ff[31] ? lvl_up : lvl_dn;
                     else
                        level_ff <= dstep_ff[31] ? lvl_dn : lvl_up;
                  end else if (shape_ff == SHAPE_EXP) begin
                     level_ff <= sum_exp[16] ? 16'hFFFF : sum_exp[15:0];
                     neg_ff   <= (prod_ff[31:16] == 0);
                  end else begin
                     if (v <= $signed({27'd0, min_ff})) neg_ff <= 1'b1;
                     else level_ff <= (v > 43'sh0FFFF) ? 16'hFFFF : v[15:0];
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (neg_ff) begin
                  sus_lvl_ff <= '0;
                  level_ff   <= min_ff;
                  active_ff  <= 1'b0;
                  elapsed_ff <= 24'd1;
               end else if (elapsed_ff != 24'hFFFFFF) elapsed_ff <= elapsed_ff + 24'd1;
               neg_ff   <= 1'b0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold here while the previous result still waits
               if (out_load) begin
                  rsp_data_ff <= {4'd0, ph_next, active_ff, level_ff};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // a waiting result stays put until its transfer
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while waiting");
   // the output state is always followed by a valid result
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid_ff) else $error("result not presented");
   // idle envelope reports idle phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[16]) |-> (rsp_data_ff[19:17] == PH_IDLE))
      else $error("phase not idle while inactive");
endmodule
